@@ rtl/sva_pkg.sv @@
// shared types and constants for the synth voice allocator
package sva_pkg;

    localparam int OP_W    = 2;
    localparam int INST_W  = 8;
    localparam int NOTE_W  = 8;
    localparam int VOICE_W = 3;
    localparam int MASK_W  = 8;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_KILL_ALL = 2'd2
    } op_t;

    // per-voice mode
    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_PLAYING  = 2'd1,
        MODE_RELEASED = 2'd2
    } mode_t;

    // allocation class, higher wins
    typedef enum logic [1:0] {
        RANK_BUSY     = 2'd0,
        RANK_RELEASED = 2'd1,
        RANK_FREE     = 2'd2
    } rank_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RELEASE,
        ST_PICK,
        ST_COMMIT,
        ST_KILL,
        ST_DONE
    } state_t;

endpackage

@@ rtl/sva_pick_unit.sv @@
// shared age and class compare unit used by the voice pick scan
module sva_pick_unit #(
    parameter int STAMP_BITS = 32
) (
    input  logic [STAMP_BITS-1:0] event_clock,
    input  logic [STAMP_BITS-1:0] stamp,
    input  sva_pkg::mode_t        mode,
    input  logic                  first,
    input  sva_pkg::rank_t        best_rank,
    input  logic [STAMP_BITS-1:0] best_age,
    output logic                  take,
    output logic [STAMP_BITS-1:0] age,
    output sva_pkg::rank_t        rank
);
    import sva_pkg::*;

    // wrapped age, larger is older
    assign age = event_clock - stamp;

    always_comb
    begin
        unique case (mode)
            MODE_FREE:     rank = RANK_FREE;
            MODE_RELEASED: rank = RANK_RELEASED;
            default:       rank = RANK_BUSY;
        endcase
    end

    // free voices: later (higher index) wins; others: strictly older wins
    always_comb
    begin
        if (first || (rank > best_rank))
            take = 1'b1;
        else if (rank == best_rank)
            take = (rank == RANK_FREE) || (age > best_age);
        else
            take = 1'b0;
    end

endmodule

@@ rtl/synth_voice_allocator.sv @@
// top level of the polyphonic voice allocator with oldest-note stealing
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | op, instrument, note
//  output   | out_valid / out_ready | voice, allocated, reinit, released_mask,
//           |                       | killed_mask
//
// one voice is visited per cycle in each scan; the pick scan uses the shared age compare unit.
// after the accept, note on runs the release scan, pick scan, commit and done; note off
// runs the release scan and done, kill all the kill scan and done, an unused op only done
// in_ready is high only in idle; a finished result sits in the output register
// so the next transaction is taken while out_ready is low
// a new result waits in the done state until the output register frees up
// reset clears all voices to free with zero instrument, note and stamp
module synth_voice_allocator #(
    parameter int VOICE_COUNT = 8,
    parameter int STAMP_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sva_pkg::OP_W-1:0]     op,
    input  logic [sva_pkg::INST_W-1:0]   instrument,
    input  logic [sva_pkg::NOTE_W-1:0]   note,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sva_pkg::VOICE_W-1:0]  voice,
    output logic                         allocated,
    output logic                         reinit,
    output logic [sva_pkg::MASK_W-1:0]   released_mask,
    output logic [sva_pkg::MASK_W-1:0]   killed_mask
);
    import sva_pkg::*;

    localparam int VW = $clog2(VOICE_COUNT);
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

    // sequencer
    state_t state_reg, state_next;
    logic [VW-1:0] scan_reg, scan_next;

    // latched transaction
    logic [OP_W-1:0]   op_reg, op_next;
    logic [INST_W-1:0] inst_reg, inst_next;
    logic [NOTE_W-1:0] note_reg, note_next;

    // voice pool and event clock
    mode_t             mode_reg  [VOICE_COUNT];
    mode_t             mode_next [VOICE_COUNT];
    logic [INST_W-1:0] vinst_reg  [VOICE_COUNT];
    logic [INST_W-1:0] vinst_next [VOICE_COUNT];
    logic [NOTE_W-1:0] vnote_reg  [VOICE_COUNT];
    logic [NOTE_W-1:0] vnote_next [VOICE_COUNT];
    logic [STAMP_BITS-1:0] stamp_reg  [VOICE_COUNT];
    logic [STAMP_BITS-1:0] stamp_next [VOICE_COUNT];
    logic [STAMP_BITS-1:0] clock_reg, clock_next;

    // pick tracker
    logic [VW-1:0]         best_reg, best_next;
    rank_t                 best_rank_reg, best_rank_next;
    logic [STAMP_BITS-1:0] best_age_reg, best_age_next;
    logic [INST_W-1:0]     best_inst_reg, best_inst_next;

    // working result
    logic [MASK_W-1:0] rel_mask_reg, rel_mask_next;
    logic [MASK_W-1:0] kill_mask_reg, kill_mask_next;
    logic              res_alloc_reg, res_alloc_next;
    logic              res_reinit_reg, res_reinit_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [VOICE_W-1:0] voice_reg, voice_next;
    logic               allocated_reg, allocated_next;
    logic               reinit_reg, reinit_next;
    logic [MASK_W-1:0]  released_reg, released_next;
    logic [MASK_W-1:0]  killed_reg, killed_next;

    // shared compare unit
    logic                  pu_take;
    logic [STAMP_BITS-1:0] pu_age;
    rank_t                 pu_rank;

    sva_pick_unit #(
        .STAMP_BITS (STAMP_BITS)
    ) u_pick (
        .event_clock (clock_reg),
        .stamp       (stamp_reg[scan_reg]),
        .mode        (mode_reg[scan_reg]),
        .first       (scan_reg == '0),
        .best_rank   (best_rank_reg),
        .best_age    (best_age_reg),
        .take        (pu_take),
        .age         (pu_age),
        .rank        (pu_rank)
    );

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign voice         = voice_reg;
    assign allocated     = allocated_reg;
    assign reinit        = reinit_reg;
    assign released_mask = released_reg;
    assign killed_mask   = killed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                mode_reg[i]  <= MODE_FREE;
                vinst_reg[i] <= '0;
                vnote_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            vinst_reg     <= vinst_next;
            vnote_reg     <= vnote_next;
            stamp_reg     <= stamp_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        inst_reg       <= inst_next;
        note_reg       <= note_next;
        best_reg       <= best_next;
        best_rank_reg  <= best_rank_next;
        best_age_reg   <= best_age_next;
        best_inst_reg  <= best_inst_next;
        rel_mask_reg   <= rel_mask_next;
        kill_mask_reg  <= kill_mask_next;
        res_alloc_reg  <= res_alloc_next;
        res_reinit_reg <= res_reinit_next;
        voice_reg      <= voice_next;
        allocated_reg  <= allocated_next;
        reinit_reg     <= reinit_next;
        released_reg   <= released_next;
        killed_reg     <= killed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        op_next         = op_reg;
        inst_next       = inst_reg;
        note_next       = note_reg;
        mode_next       = mode_reg;
        vinst_next      = vinst_reg;
        vnote_next      = vnote_reg;
        stamp_next      = stamp_reg;
        clock_next      = clock_reg;
        best_next       = best_reg;
        best_rank_next  = best_rank_reg;
        best_age_next   = best_age_reg;
        best_inst_next  = best_inst_reg;
        rel_mask_next   = rel_mask_reg;
        kill_mask_next  = kill_mask_reg;
        res_alloc_next  = res_alloc_reg;
        res_reinit_next = res_reinit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        voice_next      = voice_reg;
        allocated_next  = allocated_reg;
        reinit_next     = reinit_reg;
        released_next   = released_reg;
        killed_next     = killed_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op;
                    inst_next       = instrument;
                    note_next       = note;
                    scan_next       = '0;
                    rel_mask_next   = '0;
                    kill_mask_next  = '0;
                    res_alloc_next  = 1'b0;
                    res_reinit_next = 1'b0;
                    unique case (op)
                        OP_NOTE_ON,
                        OP_NOTE_OFF: state_next = ST_RELEASE;
                        OP_KILL_ALL: state_next = ST_KILL;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end

            // release matching playing voices, stamping in voice order
            ST_RELEASE:
            begin
                if ((mode_reg[scan_reg] == MODE_PLAYING) &&
                    (vinst_reg[scan_reg] == inst_reg) &&
                    (vnote_reg[scan_reg] == note_reg))
                begin
                    mode_next[scan_reg]  = MODE_RELEASED;
                    stamp_next[scan_reg] = clock_reg;
                    clock_next           = clock_reg + STAMP_BITS'(1);
                    rel_mask_next        = rel_mask_reg | (MASK_W'(1) << scan_reg);
                end
                if (scan_reg == LAST_VOICE)
                begin
                    scan_next  = '0;
                    state_next = (op_reg == OP_NOTE_ON) ? ST_PICK : ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + VW'(1);
                end
            end

            // class first, then age, through the shared unit
            ST_PICK:
            begin
                if (pu_take)
                begin
                    best_next      = scan_reg;
                    best_rank_next = pu_rank;
                    best_age_next  = pu_age;
                    best_inst_next = vinst_reg[scan_reg];
                end
                if (scan_reg == LAST_VOICE)
                begin
                    scan_next  = '0;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    scan_next = scan_reg + VW'(1);
                end
            end

            ST_COMMIT:
            begin
                res_alloc_next       = 1'b1;
                res_reinit_next      = (best_inst_reg != inst_reg) ||
                                       (best_rank_reg != RANK_FREE);
                mode_next[best_reg]  = MODE_PLAYING;
                vinst_next[best_reg] = inst_reg;
                vnote_next[best_reg] = note_reg;
                stamp_next[best_reg] = clock_reg;
                clock_next           = clock_reg + STAMP_BITS'(1);
                state_next           = ST_DONE;
            end

            // free every busy voice, other fields kept
            ST_KILL:
            begin
                if (mode_reg[scan_reg] != MODE_FREE)
                begin
                    mode_next[scan_reg] = MODE_FREE;
                    kill_mask_next      = kill_mask_reg | (MASK_W'(1) << scan_reg);
                end
                if (scan_reg == LAST_VOICE)
                begin
                    scan_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + VW'(1);
                end
            end

            // hand the transaction result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    voice_next     = res_alloc_reg ? VOICE_W'(best_reg) : '0;
                    allocated_next = res_alloc_reg;
                    reinit_next    = res_alloc_reg && res_reinit_reg;
                    released_next  = rel_mask_reg;
                    killed_next    = kill_mask_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the synth voice allocator
module testbench;
    import sva_pkg::*;

    localparam int VOICES     = 8;
    localparam int STAMP_BITS = 32;
    localparam int IDLE_LIMIT = 3000;   // cycles with no transaction on either side
    localparam int HOLD_LEN   = 400;    // long receiver hold-off to back up the block
    localparam int TAIL_WAIT  = 40;     // extra wait after the last prediction is consumed

    // op code 3 has no meaning and must leave the pool alone
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               allocated;
        logic               reinit;
        logic [MASK_W-1:0]  released_mask;
        logic [MASK_W-1:0]  killed_mask;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     op;
    logic [INST_W-1:0]   instrument;
    logic [NOTE_W-1:0]   note;
    logic                out_valid;
    logic                out_ready;
    logic [VOICE_W-1:0]  voice;
    logic                allocated;
    logic                reinit;
    logic [MASK_W-1:0]   released_mask;
    logic [MASK_W-1:0]   killed_mask;

    // predicted voice pool
    mode_t                 pool_mode  [VOICES];
    logic [INST_W-1:0]     pool_inst  [VOICES];
    logic [NOTE_W-1:0]     pool_note  [VOICES];
    logic [STAMP_BITS-1:0] pool_stamp [VOICES];
    logic [STAMP_BITS-1:0] stamp_clock;

    alloc_result_t expected_results[$];

    int  error_count;
    int  idle_cycles;
    int  hold_cycles;
    bit  no_idle;
    int  n_note_on, n_note_off, n_kill, n_unused, n_reinit, n_released, n_killed;

    synth_voice_allocator #(
        .VOICE_COUNT (VOICES),
        .STAMP_BITS  (STAMP_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .instrument    (instrument),
        .note          (note),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .voice         (voice),
        .allocated     (allocated),
        .reinit        (reinit),
        .released_mask (released_mask),
        .killed_mask   (killed_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one event to the predicted pool and return what the block should report
    function automatic alloc_result_t apply_event(input logic [OP_W-1:0] code,
                                                  input logic [INST_W-1:0] inst,
                                                  input logic [NOTE_W-1:0] nt);
        alloc_result_t         res;
        int                    v;
        int                    pick;
        logic [STAMP_BITS-1:0] age;
        logic [STAMP_BITS-1:0] oldest;
        res    = '0;
        pick   = -1;
        oldest = '0;
        if (code == OP_NOTE_ON || code == OP_NOTE_OFF)
        begin
            // release every playing copy of the note, stamping in voice order
            for (v = 0; v < VOICES; v++)
            begin
                if (pool_mode[v] == MODE_PLAYING && pool_inst[v] == inst && pool_note[v] == nt)
                begin
                    pool_mode[v]          = MODE_RELEASED;
                    pool_stamp[v]         = stamp_clock;
                    stamp_clock           = stamp_clock + 1'b1;
                    res.released_mask[v]  = 1'b1;
                end
            end
        end
        if (code == OP_NOTE_ON)
        begin
            // highest free voice first
            for (v = VOICES - 1; v >= 0 && pick < 0; v--)
                if (pool_mode[v] == MODE_FREE)
                    pick = v;
            // then the oldest released voice, ties to the lowest index
            if (pick < 0)
            begin
                for (v = 0; v < VOICES; v++)
                begin
                    age = stamp_clock - pool_stamp[v];
                    if (pool_mode[v] == MODE_RELEASED && (pick < 0 || age > oldest))
                    begin
                        pick   = v;
                        oldest = age;
                    end
                end
            end
            // otherwise steal the oldest playing voice
            if (pick < 0)
            begin
                for (v = 0; v < VOICES; v++)
                begin
                    age = stamp_clock - pool_stamp[v];
                    if (pick < 0 || age > oldest)
                    begin
                        pick   = v;
                        oldest = age;
                    end
                end
            end
            res.reinit        = (pool_inst[pick] != inst) || (pool_mode[pick] != MODE_FREE);
            pool_inst[pick]   = inst;
            pool_note[pick]   = nt;
            pool_mode[pick]   = MODE_PLAYING;
            pool_stamp[pick]  = stamp_clock;
            stamp_clock       = stamp_clock + 1'b1;
            res.voice         = pick[VOICE_W-1:0];
            res.allocated     = 1'b1;
        end
        else if (code == OP_KILL_ALL)
        begin
            // modes clear, instrument, note and stamp stay
            for (v = 0; v < VOICES; v++)
            begin
                if (pool_mode[v] != MODE_FREE)
                begin
                    pool_mode[v]       = MODE_FREE;
                    res.killed_mask[v] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // random voice currently playing, or -1 when none is
    function automatic int pick_sounding();
        int v;
        int start;
        start = $urandom_range(0, VOICES - 1);
        for (v = 0; v < VOICES; v++)
            if (pool_mode[(start + v) % VOICES] == MODE_PLAYING)
                return (start + v) % VOICES;
        return -1;
    endfunction

    // input side monitor: predict on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(apply_event(op, instrument, note));
            case (op)
                OP_NOTE_ON:  n_note_on++;
                OP_NOTE_OFF: n_note_off++;
                OP_KILL_ALL: n_kill++;
                default:     n_unused++;
            endcase
        end
    end

    // output side checker: compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        alloc_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (exp_res.allocated && exp_res.reinit)
                    n_reinit++;
                n_released += $countones(exp_res.released_mask);
                n_killed   += $countones(exp_res.killed_mask);
                if (voice !== exp_res.voice)
                begin
                    $error("voice: expected %0d, actual %0d", exp_res.voice, voice);
                    error_count++;
                end
                if (allocated !== exp_res.allocated)
                begin
                    $error("allocated: expected %0d, actual %0d", exp_res.allocated, allocated);
                    error_count++;
                end
                if (reinit !== exp_res.reinit)
                begin
                    $error("reinit: expected %0d, actual %0d", exp_res.reinit, reinit);
                    error_count++;
                end
                if (released_mask !== exp_res.released_mask)
                begin
                    $error("released_mask: expected %h, actual %h",
                           exp_res.released_mask, released_mask);
                    error_count++;
                end
                if (killed_mask !== exp_res.killed_mask)
                begin
                    $error("killed_mask: expected %h, actual %h",
                           exp_res.killed_mask, killed_mask);
                    error_count++;
                end
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result receiver with random stalls and an optional long hold-off
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (hold_cycles != 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // send one transaction; called and returns at a falling edge
    task automatic send_event(input logic [OP_W-1:0] code, input logic [INST_W-1:0] inst,
                              input logic [NOTE_W-1:0] nt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        instrument <= inst;
        note       <= nt;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // note off aimed at a sounding note when there is one
    task automatic send_note_off_sounding(input int aim_pct);
        int s;
        s = pick_sounding();
        if (s >= 0 && $urandom_range(0, 99) < aim_pct)
            send_event(OP_NOTE_OFF, pool_inst[s], pool_note[s]);
        else
            send_event(OP_NOTE_OFF, 8'($urandom), 8'($urandom));
    endtask

    // fill, release, steal, kill and the unused code in a fixed order
    task automatic test_directed();
        int i;
        send_event(OP_UNUSED, 8'h00, 8'h00);
        send_event(OP_NOTE_OFF, 8'h00, 8'h00);      // nothing playing
        send_event(OP_KILL_ALL, 8'h00, 8'h00);      // nothing to free
        send_event(OP_NOTE_ON, 8'h00, 8'h00);       // same instrument as reset, no reinit
        send_event(OP_NOTE_ON, 8'hFF, 8'hFF);       // new instrument on a free voice
        send_event(OP_NOTE_ON, 8'h00, 8'h00);       // retrigger releases the first copy
        for (i = 0; i < 5; i++)
            send_event(OP_NOTE_ON, (i % 2) ? 8'h0F : 8'hF0, 8'(8'h40 + i));
        send_event(OP_NOTE_ON, 8'hAA, 8'h55);       // pool full, take the released voice
        send_event(OP_NOTE_ON, 8'h55, 8'hAA);       // steal the oldest playing voice
        send_event(OP_NOTE_OFF, 8'hAA, 8'h55);
        send_event(OP_NOTE_OFF, 8'h00, 8'h00);
        send_event(OP_NOTE_ON, 8'h01, 8'h02);       // oldest of two released voices
        send_event(OP_KILL_ALL, 8'hFF, 8'hFF);
        send_event(OP_NOTE_ON, 8'h00, 8'h00);       // free again, instrument kept through kill
        send_event(OP_UNUSED, 8'hFF, 8'hFF);
        send_event(OP_NOTE_OFF, 8'hFF, 8'hFF);
        send_event(OP_KILL_ALL, 8'h00, 8'h00);
    endtask

    // mostly musical traffic with random content, bursts alternate with idling
    task automatic test_random_mix();
        int seg;
        int i;
        int roll;
        logic [INST_W-1:0] inst;
        logic [NOTE_W-1:0] nt;
        for (seg = 0; seg < 4; seg++)
        begin
            no_idle = seg[0];
            for (i = 0; i < 300; i++)
            begin
                roll = $urandom_range(0, 99);
                inst = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                nt   = $urandom_range(0, 1) ? 8'($urandom_range(60, 67)) : 8'($urandom);
                if (roll < 50)
                    send_event(OP_NOTE_ON, inst, nt);
                else if (roll < 85)
                    send_note_off_sounding(80);
                else if (roll < 92)
                    send_event(OP_KILL_ALL, 8'($urandom), 8'($urandom));
                else if (roll < 95)
                    send_event(OP_UNUSED, 8'($urandom), 8'($urandom));
                else
                    send_event(OP_NOTE_ON, 8'($urandom), 8'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // tiny note palette so retriggers and matching note offs are frequent
    task automatic test_retrigger();
        int i;
        int roll;
        for (i = 0; i < 200; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_event(OP_NOTE_ON, 8'(8'h10 + $urandom_range(0, 1)),
                           8'($urandom_range(0, 2)));
            else if (roll < 90)
                send_note_off_sounding(70);
            else if (roll < 95)
                send_event(OP_KILL_ALL, 8'($urandom), 8'($urandom));
            else
                send_event(OP_UNUSED, 8'($urandom), 8'($urandom));
        end
    endtask

    // receiver holds off while the sender keeps offering, so in_ready has to drop
    task automatic test_backpressure();
        int i;
        hold_cycles = HOLD_LEN;
        no_idle     = 1'b1;
        for (i = 0; i < 12; i++)
            send_event(OP_NOTE_ON, 8'($urandom_range(0, 3)), 8'($urandom));
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_NOTE_ON;
        instrument  = '0;
        note        = '0;
        no_idle     = 1'b0;
        hold_cycles = 0;
        error_count = 0;
        idle_cycles = 0;
        stamp_clock = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            pool_mode[v]  = MODE_FREE;
            pool_inst[v]  = '0;
            pool_note[v]  = '0;
            pool_stamp[v] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();
        test_retrigger();

        // lower valid at the edge after the last transaction and drain
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d note on (%0d reinit), %0d note off, %0d kill all, %0d unused op",
                 n_note_on, n_reinit, n_note_off, n_kill, n_unused);
        $display("voices released %0d, voices killed %0d, mismatches %0d",
                 n_released, n_killed, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sva_pkg.sv
rtl/sva_pick_unit.sv
rtl/synth_voice_allocator.sv
sim/testbench.sv
